>>> sv/rational_arithmetic_unit_top_macros.svh
// Assertion macros for the rational arithmetic unit checker.
// Depends on nothing; included by the checker file.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rau assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

>>> sv/rau_pkg.sv
// Package for the rational arithmetic unit: payload structs, codes and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none

package rau_pkg;

    typedef enum logic [2:0] {
        CMD_NORM = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_CMP  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_DIV_ZERO = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               less;
        logic               equal;
        logic [1:0]         status;
    } out_item_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_CAPTURE,
        DP_LOAD_A,
        DP_LOAD_B,
        DP_WORK_ZERO,
        DP_GCD_INIT,
        DP_GCD_STEP,
        DP_DIV_N_INIT,
        DP_DIV_D_INIT,
        DP_DIV_STEP,
        DP_DIV_N_SAVE,
        DP_DIV_D_SAVE,
        DP_STORE_A,
        DP_STORE_B,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_COMBINE,
        DP_PEND_WORK,
        DP_PEND_ERR,
        DP_PEND_CMP,
        DP_PUSH
    } dp_op_t;

    // Number of quotient bits produced by the restoring divider.
    localparam int DIV_STEPS = 64;

    typedef struct packed {
        dp_op_t  op;
        status_t err;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       zden_a;
        logic       zden_b;
        logic       work_zero;
        logic       gcd_done;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit: joins the controller and the
// datapath. Uses rau_pkg, rau_ctrl and rau_datapath.
//
//  Channel  Ports                       Payload
//  input    s_valid, s_ready, s_data    in_item_t: cmd, a_num, a_den, b_num, b_den
//  result   m_valid, m_ready, m_data    out_item_t: res_num, res_den, less, equal, status
//
// One item is worked on at a time. Each reduction of a nonzero numerator runs a
// binary GCD, one step per cycle, then two 64-step restoring divisions. An item
// with a zero denominator or an unused command skips the reductions; normalise
// runs one reduction, compare two and any other command up to three.
// Reset is synchronous and active low; it clears the controller and the result valid.
// A new item is taken while the previous result still waits; the finished
// result is held until the result register is free.
`default_nettype none

module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    // Command and status between the controller and the datapath.
    dp_cmd_t  dcmd;
    dp_stat_t dstat;

    // The controller owns both handshakes and every sequencing decision.
    rau_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dstat   (dstat),
        .dcmd    (dcmd)
    );

    // The datapath holds the captured item, the arithmetic and the result register.
    rau_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .dcmd   (dcmd),
        .dstat  (dstat),
        .m_data (m_data)
    );

endmodule

`default_nettype wire

>>> sv/rau_datapath.sv
// Datapath of the rational arithmetic unit: operand registers, binary GCD,
// restoring divider, shared multiplier and result registers. Uses rau_pkg.
`default_nettype none

module rau_datapath
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic      aclk,
    input  wire in_item_t  s_data,
    input  wire dp_cmd_t   dcmd,
    output dp_stat_t       dstat,
    output out_item_t      m_data
);

    localparam int          SH   = 32 - VALUE_WIDTH;
    localparam logic [63:0] HALF = 64'd1 << (VALUE_WIDTH - 1);

    in_item_t    item_reg;
    logic        wneg_reg;
    logic [63:0] wn_reg, wd_reg;
    logic [63:0] gx_reg, gy_reg, g_reg;
    logic [6:0]  gk_reg;
    logic [63:0] dq_reg;
    logic [64:0] dr_reg;
    logic [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic        aneg_reg, bneg_reg;
    logic [63:0] p_reg, q_reg, d_reg;
    out_item_t   pend_reg, out_reg;

    // Sign-extends the low VALUE_WIDTH bits; returns {negative, magnitude}.
    function automatic logic [32:0] take_mag(input logic [31:0] raw);
        logic signed [31:0] s;
        logic [31:0]        m;
        s = $signed(raw << SH) >>> SH;
        m = s[31] ? (~s + 32'd1) : s;
        return {s[31], m};
    endfunction

    logic [32:0] ta_n, ta_d, tb_n, tb_d;
    assign ta_n = take_mag(item_reg.a_num);
    assign ta_d = take_mag(item_reg.a_den);
    assign tb_n = take_mag(item_reg.b_num);
    assign tb_d = take_mag(item_reg.b_den);

    // Divider step.
    logic [64:0] div_try, div_sub;
    logic        div_ge;
    assign div_try = {dr_reg[63:0], dq_reg[63]};
    assign div_sub = div_try - {1'b0, g_reg};
    assign div_ge  = div_try >= {1'b0, g_reg};

    // Shared multiplier operand selection.
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    always_comb begin
        mul_a = ad_reg;
        mul_b = bd_reg;
        case (dcmd.op)
            DP_MUL0: begin
                mul_a = an_reg;
                mul_b = (item_reg.cmd == CMD_MUL) ? bn_reg : bd_reg;
            end
            DP_MUL1: begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            DP_MUL2: begin
                mul_a = ad_reg;
                mul_b = (item_reg.cmd == CMD_DIV) ? bn_reg : bd_reg;
            end
            default: begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // Combination of products into the working fraction.
    logic        is_sub, ys;
    logic [63:0] sum, dif_pq, dif_qp;
    logic        p_ge_q;
    assign is_sub = (item_reg.cmd == CMD_SUB) || (item_reg.cmd == CMD_CMP);
    assign ys     = (is_sub ? ~bneg_reg : bneg_reg) && (bn_reg != 32'd0);
    assign sum    = p_reg + q_reg;
    assign dif_pq = p_reg - q_reg;
    assign dif_qp = q_reg - p_reg;
    assign p_ge_q = p_reg >= q_reg;

    // Range check and signed numerator of the working fraction.
    logic        fit_ok;
    logic [63:0] wn_neg;
    assign fit_ok = (wd_reg <= HALF - 64'd1) &&
                    (wneg_reg ? (wn_reg <= HALF) : (wn_reg <= HALF - 64'd1));
    assign wn_neg = 64'd0 - wn_reg;

    always_ff @(posedge aclk) begin
        case (dcmd.op)
            DP_CAPTURE: item_reg <= s_data;
            DP_LOAD_A: begin
                wneg_reg <= ta_n[32] ^ ta_d[32];
                wn_reg   <= {32'd0, ta_n[31:0]};
                wd_reg   <= {32'd0, ta_d[31:0]};
            end
            DP_LOAD_B: begin
                wneg_reg <= tb_n[32] ^ tb_d[32];
                wn_reg   <= {32'd0, tb_n[31:0]};
                wd_reg   <= {32'd0, tb_d[31:0]};
            end
            DP_WORK_ZERO: begin
                wneg_reg <= 1'b0;
                wd_reg   <= 64'd1;
            end
            DP_GCD_INIT: begin
                gx_reg <= wn_reg;
                gy_reg <= wd_reg;
                gk_reg <= '0;
            end
            DP_GCD_STEP: begin
                if (!gx_reg[0] && !gy_reg[0]) begin
                    gx_reg <= gx_reg >> 1;
                    gy_reg <= gy_reg >> 1;
                    gk_reg <= gk_reg + 7'd1;
                end else if (!gx_reg[0]) begin
                    gx_reg <= gx_reg >> 1;
                end else if (!gy_reg[0]) begin
                    gy_reg <= gy_reg >> 1;
                end else if (gx_reg >= gy_reg) begin
                    gx_reg <= gx_reg - gy_reg;
                end else begin
                    gy_reg <= gy_reg - gx_reg;
                end
            end
            DP_DIV_N_INIT: begin
                g_reg  <= gy_reg << gk_reg;
                dq_reg <= wn_reg;
                dr_reg <= '0;
            end
            DP_DIV_D_INIT: begin
                g_reg  <= gy_reg << gk_reg;
                dq_reg <= wd_reg;
                dr_reg <= '0;
            end
            DP_DIV_STEP: begin
                dr_reg <= div_ge ? div_sub : div_try;
                dq_reg <= {dq_reg[62:0], div_ge};
            end
            DP_DIV_N_SAVE: wn_reg <= dq_reg;
            DP_DIV_D_SAVE: wd_reg <= dq_reg;
            DP_STORE_A: begin
                an_reg   <= wn_reg[31:0];
                ad_reg   <= wd_reg[31:0];
                aneg_reg <= wneg_reg;
            end
            DP_STORE_B: begin
                bn_reg   <= wn_reg[31:0];
                bd_reg   <= wd_reg[31:0];
                bneg_reg <= wneg_reg;
            end
            DP_MUL0: p_reg <= prod;
            DP_MUL1: q_reg <= prod;
            DP_MUL2: d_reg <= prod;
            DP_COMBINE: begin
                wd_reg <= d_reg;
                if ((item_reg.cmd == CMD_MUL) || (item_reg.cmd == CMD_DIV)) begin
                    wn_reg   <= p_reg;
                    wneg_reg <= aneg_reg ^ bneg_reg;
                end else if (aneg_reg == ys) begin
                    wn_reg   <= sum;
                    wneg_reg <= aneg_reg;
                end else if (p_ge_q) begin
                    wn_reg   <= dif_pq;
                    wneg_reg <= aneg_reg;
                end else begin
                    wn_reg   <= dif_qp;
                    wneg_reg <= ys;
                end
            end
            DP_PEND_WORK: begin
                pend_reg.less  <= 1'b0;
                pend_reg.equal <= 1'b0;
                if (fit_ok) begin
                    pend_reg.res_num <= wneg_reg ? wn_neg[31:0] : wn_reg[31:0];
                    pend_reg.res_den <= wd_reg[30:0];
                    pend_reg.status  <= ST_OK;
                end else begin
                    pend_reg.res_num <= '0;
                    pend_reg.res_den <= 31'd1;
                    pend_reg.status  <= ST_OVERFLOW;
                end
            end
            DP_PEND_ERR: begin
                pend_reg.res_num <= '0;
                pend_reg.res_den <= 31'd1;
                pend_reg.less    <= 1'b0;
                pend_reg.equal   <= 1'b0;
                pend_reg.status  <= dcmd.err;
            end
            DP_PEND_CMP: begin
                pend_reg.res_num <= '0;
                pend_reg.res_den <= 31'd1;
                pend_reg.less    <= (wn_reg != 64'd0) && wneg_reg;
                pend_reg.equal   <= wn_reg == 64'd0;
                pend_reg.status  <= ST_OK;
            end
            DP_PUSH: out_reg <= pend_reg;
            default: begin
            end
        endcase
    end

    assign dstat.cmd       = item_reg.cmd;
    assign dstat.zden_a    = item_reg.a_den[VALUE_WIDTH-1:0] == '0;
    assign dstat.zden_b    = item_reg.b_den[VALUE_WIDTH-1:0] == '0;
    assign dstat.work_zero = wn_reg == 64'd0;
    assign dstat.gcd_done  = gx_reg == 64'd0;
    assign m_data          = out_reg;

endmodule

`default_nettype wire

>>> sv/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences operand reduction,
// products and result hand-off. Uses rau_pkg.
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_stat_t dstat,
    output dp_cmd_t       dcmd
);

    localparam int          CW       = $clog2(DIV_STEPS);
    localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_LOAD_A, S_LOAD_B, S_RED, S_GCD,
        S_DIVN_INIT, S_DIVN, S_DIVN_SAVE, S_DIVD_INIT, S_DIVD, S_DIVD_SAVE,
        S_RET, S_MUL0, S_MUL1, S_MUL2, S_COMBINE, S_CMP, S_PEND, S_ERR, S_DONE
    } state_t;

    typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_t;

    state_t        state_reg, state_next;
    phase_t        ph_reg, ph_next;
    status_t       err_reg, err_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        err_next     = err_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        dcmd.op      = DP_NONE;
        dcmd.err     = err_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    dcmd.op    = DP_CAPTURE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (dstat.cmd > CMD_CMP) begin
                    err_next   = ST_OK;
                    state_next = S_ERR;
                end else if (dstat.zden_a ||
                             (dstat.cmd != CMD_NORM && dstat.zden_b)) begin
                    err_next   = ST_ZERO_DEN;
                    state_next = S_ERR;
                end else begin
                    state_next = S_LOAD_A;
                end
            end
            S_LOAD_A: begin
                dcmd.op    = DP_LOAD_A;
                ph_next    = PH_A;
                state_next = S_RED;
            end
            S_LOAD_B: begin
                dcmd.op    = DP_LOAD_B;
                ph_next    = PH_B;
                state_next = S_RED;
            end
            S_RED: begin
                if (dstat.work_zero) begin
                    dcmd.op    = DP_WORK_ZERO;
                    state_next = S_RET;
                end else begin
                    dcmd.op    = DP_GCD_INIT;
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (dstat.gcd_done) begin
                    state_next = S_DIVN_INIT;
                end else begin
                    dcmd.op = DP_GCD_STEP;
                end
            end
            S_DIVN_INIT: begin
                dcmd.op    = DP_DIV_N_INIT;
                cnt_next   = '0;
                state_next = S_DIVN;
            end
            S_DIVN: begin
                dcmd.op  = DP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_DIVN_SAVE;
                end
            end
            S_DIVN_SAVE: begin
                dcmd.op    = DP_DIV_N_SAVE;
                state_next = S_DIVD_INIT;
            end
            S_DIVD_INIT: begin
                dcmd.op    = DP_DIV_D_INIT;
                cnt_next   = '0;
                state_next = S_DIVD;
            end
            S_DIVD: begin
                dcmd.op  = DP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = S_DIVD_SAVE;
                end
            end
            S_DIVD_SAVE: begin
                dcmd.op    = DP_DIV_D_SAVE;
                state_next = S_RET;
            end
            S_RET: begin
                case (ph_reg)
                    PH_A: begin
                        dcmd.op    = DP_STORE_A;
                        state_next = (dstat.cmd == CMD_NORM) ? S_PEND : S_LOAD_B;
                    end
                    PH_B: begin
                        dcmd.op = DP_STORE_B;
                        if (dstat.cmd == CMD_DIV && dstat.work_zero) begin
                            err_next   = ST_DIV_ZERO;
                            state_next = S_ERR;
                        end else begin
                            state_next = S_MUL0;
                        end
                    end
                    default: state_next = S_PEND;
                endcase
            end
            S_MUL0: begin
                dcmd.op    = DP_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1: begin
                dcmd.op    = DP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                dcmd.op    = DP_MUL2;
                state_next = S_COMBINE;
            end
            S_COMBINE: begin
                dcmd.op = DP_COMBINE;
                if (dstat.cmd == CMD_CMP) begin
                    state_next = S_CMP;
                end else begin
                    ph_next    = PH_R;
                    state_next = S_RED;
                end
            end
            S_CMP: begin
                dcmd.op    = DP_PEND_CMP;
                state_next = S_DONE;
            end
            S_PEND: begin
                dcmd.op    = DP_PEND_WORK;
                state_next = S_DONE;
            end
            S_ERR: begin
                dcmd.op    = DP_PEND_ERR;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    dcmd.op      = DP_PUSH;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            ph_reg      <= PH_A;
            err_reg     <= ST_OK;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ph_reg      <= ph_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> sv/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Uses rau_pkg and rational_arithmetic_unit_top_macros.svh.
`default_nettype none
`include "rational_arithmetic_unit_top_macros.svh"

module rau_checker
    import rau_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire in_item_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // A result that is not taken stays offered.
    `RAU_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // Any error status comes with a cleared result.
    `RAU_ASSERT_IMP(a_err_clear, aclk, aresetn, m_valid && (m_data.status != ST_OK), (m_data.res_num == 0) && (m_data.res_den == 31'd1) && !m_data.less && !m_data.equal)

    // Less-than and equality never show together.
    `RAU_ASSERT_IMP(a_flags, aclk, aresetn, m_valid, !(m_data.less && m_data.equal))

    // A delivered denominator is never zero.
    `RAU_ASSERT_IMP(a_den_pos, aclk, aresetn, m_valid, m_data.res_den != 31'd0)

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
